// ===== rtl/core/tom_pkg.sv =====
package tom_pkg;

  localparam int unsigned IdxW   = 20;
  localparam int unsigned BoundW = 21;
  localparam int unsigned DevW   = 7;
  localparam int unsigned BlkW   = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned LinW   = IdxW + BoundW;

  localparam logic [ModeW-1:0] MODE_CYC_1D = 2'd0;
  localparam logic [ModeW-1:0] MODE_CYC_2D = 2'd1;
  localparam logic [ModeW-1:0] MODE_BLK_2D = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 3'd0,
    REG_DEV_COUNT  = 3'd1,
    REG_TILE_ROWS  = 3'd2,
    REG_TILE_COLS  = 3'd3,
    REG_GRID_ROWS  = 3'd4,
    REG_GRID_COLS  = 3'd5,
    REG_BLOCK_ROWS = 3'd6,
    REG_BLOCK_COLS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [DevW-1:0]   device_count;
    logic [BoundW-1:0] tile_rows;
    logic [BoundW-1:0] tile_cols;
    logic [DevW-1:0]   grid_rows;
    logic [DevW-1:0]   grid_cols;
    logic [BlkW-1:0]   block_rows;
    logic [BlkW-1:0]   block_cols;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0] tile_row;
    logic [IdxW-1:0] tile_col;
  } in_t;

  typedef struct packed {
    logic [DevW-1:0] owner;
    logic            status;
  } out_t;

endpackage

// ===== rtl/core/tom_cfg_regs.sv =====
module tom_cfg_regs import tom_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:       cfg_d.mode         = cfg_data_i[ModeW-1:0];
        REG_DEV_COUNT:  cfg_d.device_count = cfg_data_i[DevW-1:0];
        REG_TILE_ROWS:  cfg_d.tile_rows    = cfg_data_i[BoundW-1:0];
        REG_TILE_COLS:  cfg_d.tile_cols    = cfg_data_i[BoundW-1:0];
        REG_GRID_ROWS:  cfg_d.grid_rows    = cfg_data_i[DevW-1:0];
        REG_GRID_COLS:  cfg_d.grid_cols    = cfg_data_i[DevW-1:0];
        REG_BLOCK_ROWS: cfg_d.block_rows   = cfg_data_i[BlkW-1:0];
        REG_BLOCK_COLS: cfg_d.block_cols   = cfg_data_i[BlkW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_CYC_2D;
      cfg_q.device_count <= DevW'(1);
      cfg_q.tile_rows    <= BoundW'(1);
      cfg_q.tile_cols    <= BoundW'(1);
      cfg_q.grid_rows    <= DevW'(1);
      cfg_q.grid_cols    <= DevW'(1);
      cfg_q.block_rows   <= BlkW'(1);
      cfg_q.block_cols   <= BlkW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/tom_divpipe.sv =====
// restoring divider, one quotient bit per stage
module tom_divpipe #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 16,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] r_nx;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = vld_q[s-1];
      assign r_in = rem_q[s-1];
      assign n_in = num_q[s-1];
      assign q_in = quo_q[s-1];
      assign d_in = den_q[s-1];
      assign t_in = tag_q[s-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign fits  = (trial >= {1'b0, d_in});
    assign r_nx  = fits ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= r_nx;
        num_q[s] <= {n_in[NW-2:0], 1'b0};
        quo_q[s] <= {q_in[NW-2:0], fits};
        den_q[s] <= d_in;
        tag_q[s] <= t_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

// ===== rtl/core/tile_owner_mapper.sv =====
// tile owner mapper: turns a tile coordinate into the number of the device that
// owns it, counted from 1, for 1d cyclic, 2d cyclic and 2d block-cyclic layouts
// channels: in_* carries one coordinate per transfer, out_* one owner/status
// per transfer; both use valid with a stall driven by the receiving side
// cfg_* writes one register per transfer (index, data); ready is always high
// and registers should only be rewritten while the pipeline is empty
// pipeline depth: 85 register stages, set by the chain of bit-serial
// divider stages (20 for block division, 20 for grid reduction, 41 for
// the final reduction by the device count) plus input, multiply, combine
// and output registers
// throughput: one coordinate per cycle while the output is not stalled
// stall: while a result sits in the output register and the receiver stalls,
// the whole pipeline holds and in_stall_o is raised; nothing is lost
// reset: pipeline valids clear, registers return to mode 2d cyclic and every
// count/size to 1
// out-of-range index or unused mode gives status 1 with owner 0
module tile_owner_mapper import tom_pkg::*; #(
  parameter int unsigned MAX_DEVICES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned TagW = 1 + LinW + IdxW;

  cfg_t cfg;

  tom_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // single advance enable for every stage
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // sanitised configuration; the user must keep it static while items are in flight, the block does not enforce it
  logic [DevW-1:0] cnt;
  logic [DevW-1:0] grid_r, grid_c;
  logic [BlkW-1:0] blk_r, blk_c;

  always_comb begin
    cnt = (cfg.device_count == '0) ? DevW'(1) : cfg.device_count;
    if (32'(cnt) > MAX_DEVICES) begin
      cnt = DevW'(MAX_DEVICES);
    end
    grid_r = (cfg.grid_rows == '0) ? DevW'(1) : cfg.grid_rows;
    grid_c = (cfg.grid_cols == '0) ? DevW'(1) : cfg.grid_cols;
    blk_r  = (cfg.block_rows == '0) ? BlkW'(1) : cfg.block_rows;
    blk_c  = (cfg.block_cols == '0) ? BlkW'(1) : cfg.block_cols;
  end

  // input register
  logic in_vld_q;
  in_t  in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  // range check and row-major product
  logic            err_d;
  logic [LinW-1:0] prod_d;

  always_comb begin
    unique case (cfg.mode)
      MODE_CYC_1D: err_d = (BoundW'(in_q.tile_col) >= cfg.tile_cols);
      MODE_CYC_2D,
      MODE_BLK_2D: err_d = (BoundW'(in_q.tile_row) >= cfg.tile_rows) ||
                           (BoundW'(in_q.tile_col) >= cfg.tile_cols);
      default:     err_d = 1'b1;
    endcase
    prod_d = LinW'(in_q.tile_row) * LinW'(cfg.tile_cols);
  end

  logic            s1_vld_q;
  logic            s1_err_q;
  logic [LinW-1:0] s1_prod_q;
  logic [IdxW-1:0] s1_row_q, s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_err_q  <= err_d;
      s1_prod_q <= prod_d;
      s1_row_q  <= in_q.tile_row;
      s1_col_q  <= in_q.tile_col;
    end
  end

  // block division, row and column side by side
  logic            bd_vld;
  logic [IdxW-1:0] br_quo, bc_quo;
  logic [BlkW-1:0] br_rem, bc_rem;
  logic [TagW-1:0] bd_tag;
  logic            bc_vld;
  logic            bc_tag;

  tom_divpipe #(.NW(IdxW), .DW(BlkW), .TW(TagW)) u_blk_row (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (s1_vld_q),
    .num_i   (s1_row_q),
    .den_i   (blk_r),
    .tag_i   ({s1_err_q, s1_prod_q, s1_col_q}),
    .valid_o (bd_vld),
    .quo_o   (br_quo),
    .rem_o   (br_rem),
    .tag_o   (bd_tag)
  );

  tom_divpipe #(.NW(IdxW), .DW(BlkW), .TW(1)) u_blk_col (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (s1_vld_q),
    .num_i   (s1_col_q),
    .den_i   (blk_c),
    .tag_i   (1'b0),
    .valid_o (bc_vld),
    .quo_o   (bc_quo),
    .rem_o   (bc_rem),
    .tag_o   (bc_tag)
  );

  // reduction onto the device grid
  logic            gd_vld;
  logic [IdxW-1:0] gr_quo, gc_quo;
  logic [DevW-1:0] pr, pc;
  logic [TagW-1:0] gd_tag;
  logic            gc_vld;
  logic            gc_tag;

  tom_divpipe #(.NW(IdxW), .DW(DevW), .TW(TagW)) u_grid_row (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (bd_vld),
    .num_i   (br_quo),
    .den_i   (grid_r),
    .tag_i   (bd_tag),
    .valid_o (gd_vld),
    .quo_o   (gr_quo),
    .rem_o   (pr),
    .tag_o   (gd_tag)
  );

  tom_divpipe #(.NW(IdxW), .DW(DevW), .TW(1)) u_grid_col (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (bc_vld),
    .num_i   (bc_quo),
    .den_i   (grid_c),
    .tag_i   (bc_tag),
    .valid_o (gc_vld),
    .quo_o   (gc_quo),
    .rem_o   (pc),
    .tag_o   (gc_tag)
  );

  // pick the linear index for the current mode
  logic            gd_err;
  logic [LinW-1:0] gd_prod;
  logic [IdxW-1:0] gd_col;
  logic [LinW-1:0] lin_d;

  assign {gd_err, gd_prod, gd_col} = gd_tag;

  always_comb begin
    unique case (cfg.mode)
      MODE_CYC_1D: lin_d = LinW'(gd_col);
      MODE_CYC_2D: lin_d = gd_prod + LinW'(gd_col);
      default:     lin_d = LinW'(pr) * LinW'(grid_c) + LinW'(pc);
    endcase
  end

  logic            cb_vld_q;
  logic            cb_err_q;
  logic [LinW-1:0] cb_lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_vld_q <= 1'b0;
    end else if (en) begin
      cb_vld_q <= gd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cb_err_q <= gd_err;
      cb_lin_q <= lin_d;
    end
  end

  // final reduction by the device count
  logic            fm_vld;
  logic [LinW-1:0] fm_quo;
  logic [DevW-1:0] fm_rem;
  logic            fm_err;

  tom_divpipe #(.NW(LinW), .DW(DevW), .TW(1)) u_dev_mod (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (cb_vld_q),
    .num_i   (cb_lin_q),
    .den_i   (cnt),
    .tag_i   (cb_err_q),
    .valid_o (fm_vld),
    .quo_o   (fm_quo),
    .rem_o   (fm_rem),
    .tag_o   (fm_err)
  );

  // output register
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fm_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.owner  <= fm_err ? '0 : DevW'(fm_rem + DevW'(1));
      out_q.status <= fm_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tile_owner_mapper_tb.sv =====
module tile_owner_mapper_tb;
  import tom_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth given at the head of the block, with margin
  localparam int unsigned Latency   = 85;
  localparam int unsigned DrainWait = 2 * Latency + 20;
  localparam int unsigned MaxDev    = 64;
  localparam int unsigned NumRand   = 1650;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  tile_owner_mapper dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // clock: 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // own copy of the register file, written alongside the block
  cfg_t layout;

  // owners still on their way through the pipeline
  out_t owners_due[$];
  int   mismatches;
  int   checked;
  int   errors_seen;
  bit   hold_off;

  // owner of one tile under the current layout
  function automatic out_t owner_of(in_t t);
    out_t        r;
    logic [63:0] cnt, lin, gr, gc, br, bc;
    logic [63:0] row, col;
    bit          bad;
    row = 64'(t.tile_row);
    col = 64'(t.tile_col);
    cnt = (layout.device_count == 0) ? 64'd1 : 64'(layout.device_count);
    if (cnt > MaxDev) begin
      cnt = MaxDev;
    end
    lin = 0;
    bad = 1'b0;
    if (layout.mode == MODE_CYC_1D) begin
      bad = col >= 64'(layout.tile_cols);
      lin = col;
    end else if (layout.mode == MODE_CYC_2D || layout.mode == MODE_BLK_2D) begin
      bad = row >= 64'(layout.tile_rows) || col >= 64'(layout.tile_cols);
      if (layout.mode == MODE_CYC_2D) begin
        lin = row * 64'(layout.tile_cols) + col;
      end else begin
        gr  = (layout.grid_rows == 0) ? 64'd1 : 64'(layout.grid_rows);
        gc  = (layout.grid_cols == 0) ? 64'd1 : 64'(layout.grid_cols);
        br  = (layout.block_rows == 0) ? 64'd1 : 64'(layout.block_rows);
        bc  = (layout.block_cols == 0) ? 64'd1 : 64'(layout.block_cols);
        lin = ((row / br) % gr) * gc + ((col / bc) % gc);
      end
    end else begin
      bad = 1'b1;
    end
    if (bad) begin
      r.owner  = '0;
      r.status = 1'b1;
    end else begin
      r.owner  = DevW'(64'd1 + lin % cnt);
      r.status = 1'b0;
    end
    return r;
  endfunction

  // register write while the pipeline is empty
  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:       layout.mode         = val[ModeW-1:0];
      REG_DEV_COUNT:  layout.device_count = val[DevW-1:0];
      REG_TILE_ROWS:  layout.tile_rows    = val[BoundW-1:0];
      REG_TILE_COLS:  layout.tile_cols    = val[BoundW-1:0];
      REG_GRID_ROWS:  layout.grid_rows    = val[DevW-1:0];
      REG_GRID_COLS:  layout.grid_cols    = val[DevW-1:0];
      REG_BLOCK_ROWS: layout.block_rows   = val[BlkW-1:0];
      default:        layout.block_cols   = val[BlkW-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_layout(cfg_t c);
    write_reg(REG_MODE, CfgDataW'(c.mode));
    write_reg(REG_DEV_COUNT, CfgDataW'(c.device_count));
    write_reg(REG_TILE_ROWS, CfgDataW'(c.tile_rows));
    write_reg(REG_TILE_COLS, CfgDataW'(c.tile_cols));
    write_reg(REG_GRID_ROWS, CfgDataW'(c.grid_rows));
    write_reg(REG_GRID_COLS, CfgDataW'(c.grid_cols));
    write_reg(REG_BLOCK_ROWS, CfgDataW'(c.block_rows));
    write_reg(REG_BLOCK_COLS, CfgDataW'(c.block_cols));
  endtask

  // offer one tile and hold it until the transfer; called at a falling edge,
  // returns at the falling edge after the transfer with valid still high
  task automatic send_tile(in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    owners_due.push_back(owner_of(t));
    if (owners_due[$].status) begin
      errors_seen++;
    end
    @(negedge clk);
  endtask

  // random gap between bursts; lowers valid only when a gap follows
  task automatic maybe_gap(ref int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait for the pipeline to empty, then for the latency so nothing is in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (owners_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainWait) @(negedge clk);
  endtask

  function automatic logic [19:0] rand_idx(logic [BoundW-1:0] bound);
    int unsigned b;
    b = (bound == 0) ? 1 : ((bound > 21'd1048576) ? 1048576 : int'(bound));
    case ($urandom_range(0, 9))
      0:       return 20'($urandom());
      1:       return 20'(b - 1);
      2:       return 20'(b);
      default: return 20'($urandom_range(0, b - 1));
    endcase
  endfunction

  // random layout: mostly small and sensible, sometimes extremes and odd values
  function automatic cfg_t rand_layout();
    cfg_t c;
    c.mode = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    c.device_count = ($urandom_range(0, 7) == 0) ? 7'($urandom()) :
                     7'($urandom_range(1, 64));
    c.tile_rows = ($urandom_range(0, 7) == 0) ? 21'($urandom()) :
                  21'($urandom_range(1, 300));
    c.tile_cols = ($urandom_range(0, 7) == 0) ? 21'($urandom()) :
                  21'($urandom_range(1, 300));
    c.grid_rows = ($urandom_range(0, 7) == 0) ? 7'($urandom()) :
                  7'($urandom_range(1, 8));
    c.grid_cols = ($urandom_range(0, 7) == 0) ? 7'($urandom()) :
                  7'($urandom_range(1, 8));
    c.block_rows = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                   16'($urandom_range(1, 20));
    c.block_cols = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                   16'($urandom_range(1, 20));
    return c;
  endfunction

  // directed table: one row per tile, a layout change where cfg_set is high
  typedef struct {
    bit   cfg_set;
    cfg_t c;
    in_t  t;
    bit   known;
    out_t want;
  } tile_row_t;

  tile_row_t tbl[$];

  function automatic cfg_t mk(logic [1:0] m, int dc, int tr, int tc,
                              int gr, int gc, int br, int bc);
    cfg_t c;
    c = '{m, 7'(dc), 21'(tr), 21'(tc), 7'(gr), 7'(gc), 16'(br), 16'(bc)};
    return c;
  endfunction

  function automatic void add(bit s, cfg_t c, int r, int col, bit k, int ow, bit st);
    tile_row_t e;
    e.cfg_set = s;
    e.c       = c;
    e.t       = '{20'(r), 20'(col)};
    e.known   = k;
    e.want    = '{7'(ow), st};
    tbl.push_back(e);
  endfunction

  initial begin
    cfg_t rst_c, c1d, c2d, cblk, codd, cmax, cbad;
    rst_c = mk(MODE_CYC_2D, 1, 1, 1, 1, 1, 1, 1);
    c1d   = mk(MODE_CYC_1D, 64, 1, 1048576, 1, 1, 1, 1);
    c2d   = mk(MODE_CYC_2D, 5, 1048576, 1048576, 1, 1, 1, 1);
    cblk  = mk(MODE_BLK_2D, 6, 100, 100, 2, 3, 4, 5);
    codd  = mk(MODE_BLK_2D, 0, 2000000, 0, 0, 0, 0, 0);
    cmax  = mk(MODE_BLK_2D, 127, 1048576, 1048576, 64, 64, 65535, 65535);
    cbad  = mk(2'd3, 4, 10, 10, 1, 1, 1, 1);
    // after reset: single device, one tile
    add(0, rst_c, 0, 0, 1, 1, 0);
    add(0, rst_c, 1, 0, 1, 0, 1);
    add(0, rst_c, 0, 1, 1, 0, 1);
    add(0, rst_c, 1048575, 1048575, 1, 0, 1);
    // 1d cyclic, row ignored
    add(1, c1d, 1048575, 0, 1, 1, 0);
    add(0, c1d, 0, 63, 1, 64, 0);
    add(0, c1d, 0, 64, 1, 1, 0);
    add(0, c1d, 0, 1048575, 1, 64, 0);
    // 2d cyclic at the largest bounds
    add(1, c2d, 1048575, 1048575, 0, 0, 0);
    add(0, c2d, 0, 0, 1, 1, 0);
    add(0, c2d, 1, 3, 0, 0, 0);
    // block-cyclic, boundaries of blocks and of the bounds
    add(1, cblk, 0, 0, 1, 1, 0);
    add(0, cblk, 4, 5, 0, 0, 0);
    add(0, cblk, 99, 99, 0, 0, 0);
    add(0, cblk, 100, 0, 1, 0, 1);
    add(0, cblk, 0, 100, 1, 0, 1);
    // zero sizes count as one, zero column bound rejects all
    add(1, codd, 5, 0, 1, 0, 1);
    add(1, mk(MODE_BLK_2D, 0, 10, 10, 0, 0, 0, 0), 9, 9, 1, 1, 0);
    // device count above the maximum saturates, largest block sizes
    add(1, cmax, 1048575, 1048575, 0, 0, 0);
    add(0, cmax, 65535, 65535, 0, 0, 0);
    add(0, cmax, 65536, 65536 * 63, 0, 0, 0);
    // unused mode
    add(1, cbad, 0, 0, 1, 0, 1);
    add(0, cbad, 9, 9, 1, 0, 1);
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int phase;
    out_stall <= 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      phase = (phase + 1) % 64;
      if (phase < 16) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owners_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result owner=%0d status=%0b",
                   out_data.owner, out_data.status);
        end
      end else begin
        want = owners_due.pop_front();
        checked++;
        if (out_data.owner !== want.owner || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: owner exp %0d got %0d, status exp %0b got %0b",
                     want.owner, out_data.owner, want.status, out_data.status);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int   burst;
    int   n;
    bit   held;
    cfg_t c;
    in_t  t;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mismatches = 0;
    checked    = 0;
    errors_seen = 0;
    hold_off   = 1'b0;
    held       = 1'b0;
    layout     = '{MODE_CYC_2D, 7'd1, 21'd1, 21'd1, 7'd1, 7'd1, 16'd1, 16'd1};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    foreach (tbl[i]) begin
      if (tbl[i].cfg_set) begin
        drain();
        write_layout(tbl[i].c);
      end
      if (tbl[i].known && owner_of(tbl[i].t) !== tbl[i].want) begin
        mismatches++;
        $display("table row %0d disagrees with typed owner %0d/%0b", i,
                 tbl[i].want.owner, tbl[i].want.status);
      end
      send_tile(tbl[i].t);
    end
    drain();

    // random phases of tiles under random layouts
    n = 0;
    burst = 0;
    while (n < NumRand) begin
      c = rand_layout();
      write_layout(c);
      if (!held && n >= 200) begin
        hold_off = 1'b1;
        held     = 1'b1;
      end
      repeat ($urandom_range(40, 120)) begin
        t.tile_row = rand_idx(layout.tile_rows);
        t.tile_col = rand_idx(layout.tile_cols);
        send_tile(t);
        maybe_gap(burst);
        n++;
      end
      drain();
    end

    $display("covered %0d tiles over random and edge layouts, %0d out-of-range",
             checked, errors_seen);
    if (mismatches == 0 && owners_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
